// ===== design/v3alu_pkg.sv =====
// Shared constants, types and saturation helpers for the three-component vector unit.
package v3alu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SQRT_STEPS = 32;
    localparam int DVD_W      = 32 + FRAC_BITS;
    localparam int DIV_STEPS  = DVD_W;
    localparam int LATENCY    = 3 + SQRT_STEPS + DIV_STEPS;

    typedef enum logic [2:0] {
        MODE_SCALE,
        MODE_NEG,
        MODE_SUB,
        MODE_ADD,
        MODE_DOT,
        MODE_CROSS,
        MODE_DIV,
        MODE_NORM
    } t_mode;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_DIV_ZERO,
        ERR_ZERO_VEC
    } t_err;

    // Item context carried alongside the square root pipeline.
    typedef struct packed {
        t_mode             mode;
        t_err              err;
        logic [2:0][31:0]  a;
        logic [32:0]       abs_s;
        logic              neg_s;
        logic [2:0][31:0]  early;
    } t_tag;

    // Item context carried alongside the dividers.
    typedef struct packed {
        logic              div_op;
        t_err              err;
        logic [2:0]        neg;
        logic [2:0][31:0]  early;
    } t_otag;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    // Floor by 2^FRAC_BITS, then clamp to the signed 32-bit range.
    function automatic logic [31:0] sat_floor(input logic signed [65:0] v);
        logic signed [65:0] sh;
        sh = v >>> FRAC_BITS;
        if (sh > SAT_MAX) begin
            return 32'h7FFF_FFFF;
        end else if (sh < SAT_MIN) begin
            return 32'h8000_0000;
        end
        return sh[31:0];
    endfunction

    function automatic logic [31:0] sat_add(input logic [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    // Apply the sign to a quotient magnitude and clamp.
    function automatic logic [31:0] sat_quot(input logic [DVD_W-1:0] q, input logic neg);
        if (!neg) begin
            if (q > DVD_W'(64'h7FFF_FFFF)) begin
                return 32'h7FFF_FFFF;
            end
            return q[31:0];
        end
        if (q > DVD_W'(64'h8000_0000)) begin
            return 32'h8000_0000;
        end
        return 32'd0 - q[31:0];
    endfunction

endpackage

// ===== design/v3alu_lane.sv =====
// One component lane: the two multipliers and the add, subtract and negate path.
module v3alu_lane (
    input  logic                i_clk,
    input  v3alu_pkg::t_mode    i_mode,
    input  logic signed [31:0]  i_a,
    input  logic signed [31:0]  i_b,
    input  logic signed [31:0]  i_s,
    input  logic signed [31:0]  i_a1,
    input  logic signed [31:0]  i_b1,
    input  logic signed [31:0]  i_a2,
    input  logic signed [31:0]  i_b2,
    output logic signed [63:0]  o_p1,
    output logic signed [63:0]  o_p2,
    output logic [31:0]         o_simple
);
    import v3alu_pkg::*;

    logic signed [31:0] m1a;
    logic signed [31:0] m1b;
    logic [32:0]        sum;
    logic signed [63:0] r_p1;
    logic signed [63:0] r_p2;
    logic [31:0]        r_simple;

    // Normalize squares the component, so both operands default to a.
    always_comb begin
        m1a = i_a;
        m1b = i_a;
        case (i_mode)
            MODE_SCALE: m1b = i_s;
            MODE_DOT:   m1b = i_b;
            MODE_CROSS: begin
                m1a = i_a1;
                m1b = i_b2;
            end
            default: ;
        endcase
    end

    always_comb begin
        case (i_mode)
            MODE_NEG: sum = 33'd0 - {i_a[31], i_a};
            MODE_SUB: sum = {i_a[31], i_a} - {i_b[31], i_b};
            MODE_ADD: sum = {i_a[31], i_a} + {i_b[31], i_b};
            default:  sum = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_p1     <= m1a * m1b;
        r_p2     <= i_a2 * i_b1;
        r_simple <= sat_add(sum);
    end

    assign o_p1     = r_p1;
    assign o_p2     = r_p2;
    assign o_simple = r_simple;

endmodule

// ===== design/v3alu_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module v3alu_sqrt (
    input  logic        i_clk,
    input  logic [63:0] i_sq,
    output logic [31:0] o_root
);
    import v3alu_pkg::*;

    logic [63:0] r_rem  [SQRT_STEPS];
    logic [63:0] r_root [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] src_rem;
        logic [63:0] src_root;
        logic [63:0] trial;
        logic [63:0] n_rem;
        logic [63:0] n_root;

        if (k == 0) begin : g_first
            assign src_rem  = i_sq;
            assign src_root = '0;
        end else begin : g_next
            assign src_rem  = r_rem[k-1];
            assign src_root = r_root[k-1];
        end

        always_comb begin
            trial = src_root + BIT;
            if (src_rem >= trial) begin
                n_rem  = src_rem - trial;
                n_root = (src_root >> 1) + BIT;
            end else begin
                n_rem  = src_rem;
                n_root = src_root >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_root[k] <= n_root;
        end
    end

    // The final root is below 2^32 for any sum of three squared 32-bit values.
    assign o_root = r_root[SQRT_STEPS-1][31:0];

endmodule

// ===== design/v3alu_div.sv =====
// Pipelined restoring divider for unsigned magnitudes, one quotient bit per stage.
module v3alu_div (
    input  logic                              i_clk,
    input  logic [v3alu_pkg::DVD_W-1:0]       i_dividend,
    input  logic [32:0]                       i_divisor,
    output logic [v3alu_pkg::DVD_W-1:0]       o_quot
);
    import v3alu_pkg::*;

    logic [32:0]      r_rem [DIV_STEPS];
    logic [DVD_W-1:0] r_dq  [DIV_STEPS];
    logic [32:0]      r_dvs [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [32:0]      src_rem;
        logic [DVD_W-1:0] src_dq;
        logic [32:0]      src_dvs;
        logic [33:0]      trial;
        logic             qbit;
        logic [32:0]      n_rem;

        if (k == 0) begin : g_first
            assign src_rem = '0;
            assign src_dq  = i_dividend;
            assign src_dvs = i_divisor;
        end else begin : g_next
            assign src_rem = r_rem[k-1];
            assign src_dq  = r_dq[k-1];
            assign src_dvs = r_dvs[k-1];
        end

        always_comb begin
            trial = {src_rem, src_dq[DVD_W-1]};
            qbit  = (trial >= {1'b0, src_dvs});
            if (qbit) begin
                n_rem = 33'(trial - {1'b0, src_dvs});
            end else begin
                n_rem = trial[32:0];
            end
        end

        // Dividend bits shift out at the top while quotient bits shift in below.
        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_dq[k]  <= {src_dq[DVD_W-2:0], qbit};
            r_dvs[k] <= src_dvs;
        end
    end

    assign o_quot = r_dq[DIV_STEPS-1];

endmodule

// ===== design/vector3_alu_top.sv =====
// Top level of the three-component Q16.16 vector unit: lanes, merge, square root and dividers.
// Every mode alike takes the same path through the merge, square root and divider pipelines; results are Q16.16.
// One item is accepted every cycle; busy is always low.
// Most of the pipeline depth comes from the 32-stage square root followed by the per-lane restoring divider.
// The result is shown on the output ports for one cycle with o_valid; the receiver cannot stall.
// Synchronous reset clears only the valid pipeline; data registers are not reset.
module vector3_alu_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_mode,
    input  logic signed [31:0]  i_a_x,
    input  logic signed [31:0]  i_a_y,
    input  logic signed [31:0]  i_a_z,
    input  logic signed [31:0]  i_b_x,
    input  logic signed [31:0]  i_b_y,
    input  logic signed [31:0]  i_b_z,
    input  logic signed [31:0]  i_scalar,
    output logic signed [31:0]  o_result_x,
    output logic signed [31:0]  o_result_y,
    output logic signed [31:0]  o_result_z,
    output logic [1:0]          o_error_code,
    output logic                o_valid
);
    import v3alu_pkg::*;

    t_mode              in_mode;
    logic signed [31:0] av [3];
    logic signed [31:0] bv [3];
    logic signed [63:0] lane_p1 [3];
    logic signed [63:0] lane_p2 [3];
    logic [31:0]        lane_simple [3];

    logic               r_v1;
    t_mode              r_mode1;
    logic [2:0][31:0]   r_a1;
    logic [31:0]        r_s1;

    logic signed [65:0] dot_sum;
    logic signed [65:0] diff [3];
    t_tag               n_tag2;
    t_tag               r_tag2;
    logic [63:0]        r_sq;
    logic               r_v2;

    logic [31:0]           root;
    t_tag                  r_tq [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] r_vq;
    t_tag                  tq;
    logic [32:0]           divisor;
    logic [DVD_W-1:0]      dividend [3];
    logic [DVD_W-1:0]      quot [3];
    t_otag                 n_otag;
    t_otag                 r_td [DIV_STEPS];
    logic [DIV_STEPS-1:0]  r_vd;
    t_otag                 ot;

    logic [2:0][31:0]   n_res;
    logic [2:0][31:0]   r_res;
    t_err               r_err;
    logic               r_valid;

    assign busy    = 1'b0;
    assign in_mode = t_mode'(i_mode);
    assign av[0] = i_a_x;
    assign av[1] = i_a_y;
    assign av[2] = i_a_z;
    assign bv[0] = i_b_x;
    assign bv[1] = i_b_y;
    assign bv[2] = i_b_z;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        v3alu_lane u_lane (
            .i_clk    (i_clk),
            .i_mode   (in_mode),
            .i_a      (av[i]),
            .i_b      (bv[i]),
            .i_s      (i_scalar),
            .i_a1     (av[(i+1)%3]),
            .i_b1     (bv[(i+1)%3]),
            .i_a2     (av[(i+2)%3]),
            .i_b2     (bv[(i+2)%3]),
            .o_p1     (lane_p1[i]),
            .o_p2     (lane_p2[i]),
            .o_simple (lane_simple[i])
        );
    end

    always_ff @(posedge i_clk) begin
        r_mode1 <= in_mode;
        r_a1    <= {i_a_z, i_a_y, i_a_x};
        r_s1    <= i_scalar;
    end

    // Merge stage: the dot product and the sum of squares share one three-way add.
    always_comb begin
        dot_sum = 66'(lane_p1[0]) + 66'(lane_p1[1]) + 66'(lane_p1[2]);
        n_tag2.mode  = r_mode1;
        n_tag2.a     = r_a1;
        n_tag2.neg_s = r_s1[31];
        n_tag2.abs_s = r_s1[31] ? (33'd0 - {1'b1, r_s1}) : {1'b0, r_s1};
        n_tag2.err   = ERR_NONE;
        if (r_mode1 == MODE_DIV && r_s1 == 32'd0) begin
            n_tag2.err = ERR_DIV_ZERO;
        end else if (r_mode1 == MODE_NORM && dot_sum == 66'sd0) begin
            n_tag2.err = ERR_ZERO_VEC;
        end
        for (int i = 0; i < 3; i++) begin
            diff[i] = 66'(lane_p1[i]) - 66'(lane_p2[i]);
            case (r_mode1) inside
                MODE_SCALE: n_tag2.early[i] = sat_floor(66'(lane_p1[i]));
                MODE_CROSS: n_tag2.early[i] = sat_floor(diff[i]);
                MODE_DOT:   n_tag2.early[i] = (i == 0) ? sat_floor(dot_sum) : 32'd0;
                MODE_NEG, MODE_SUB, MODE_ADD: n_tag2.early[i] = lane_simple[i];
                default:    n_tag2.early[i] = 32'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag2 <= n_tag2;
        r_sq   <= dot_sum[63:0];
    end

    v3alu_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_sq   (r_sq),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        r_tq[0] <= r_tag2;
        for (int k = 1; k < SQRT_STEPS; k++) begin
            r_tq[k] <= r_tq[k-1];
        end
    end

    assign tq      = r_tq[SQRT_STEPS-1];
    assign divisor = (tq.mode == MODE_NORM) ? {1'b0, root} : tq.abs_s;

    always_comb begin
        n_otag.div_op = (tq.mode == MODE_DIV) || (tq.mode == MODE_NORM);
        n_otag.err    = tq.err;
        n_otag.early  = tq.early;
        for (int i = 0; i < 3; i++) begin
            dividend[i]  = {(tq.a[i][31] ? 32'd0 - tq.a[i] : tq.a[i]), FRAC_BITS'(0)};
            n_otag.neg[i] = tq.a[i][31] ^ ((tq.mode == MODE_DIV) && tq.neg_s);
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        v3alu_div u_div (
            .i_clk      (i_clk),
            .i_dividend (dividend[i]),
            .i_divisor  (divisor),
            .o_quot     (quot[i])
        );
    end

    always_ff @(posedge i_clk) begin
        r_td[0] <= n_otag;
        for (int k = 1; k < DIV_STEPS; k++) begin
            r_td[k] <= r_td[k-1];
        end
    end

    assign ot = r_td[DIV_STEPS-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (ot.err != ERR_NONE) begin
                n_res[i] = 32'd0;
            end else if (ot.div_op) begin
                n_res[i] = sat_quot(quot[i], ot.neg[i]);
            end else begin
                n_res[i] = ot.early[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_err <= ot.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_vq    <= '0;
            r_vd    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_v1    <= start;
            r_v2    <= r_v1;
            r_vq    <= {r_vq[SQRT_STEPS-2:0], r_v2};
            r_vd    <= {r_vd[DIV_STEPS-2:0], r_vq[SQRT_STEPS-1]};
            r_valid <= r_vd[DIV_STEPS-1];
        end
    end

    assign o_result_x   = r_res[0];
    assign o_result_y   = r_res[1];
    assign o_result_z   = r_res[2];
    assign o_error_code = r_err;
    assign o_valid      = r_valid;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_valid)
        else $error("accepted item did not produce a result at the fixed latency");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != ERR_NONE |->
            o_result_x == 32'sd0 && o_result_y == 32'sd0 && o_result_z == 32'sd0)
        else $error("error result carries nonzero components");

    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && r_tag2.err == ERR_ZERO_VEC |-> r_sq == 64'd0)
        else $error("zero vector flagged with nonzero squared length");
`endif

endmodule
